/* rtl/assert_macros.svh */
// Assertion helpers for the schedule checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wcrs_pkg.sv */
package wcrs_pkg;

    // Schedule modes
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_COSINE = 2'd1;
    localparam logic [1:0] MODE_WARMUP = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_FIRST  = 3'd1;
    localparam logic [2:0] REG_LAST   = 3'd2;
    localparam logic [2:0] REG_SWITCH = 3'd3;
    localparam logic [2:0] REG_BEGIN  = 3'd4;
    localparam logic [2:0] REG_END    = 3'd5;

endpackage

/* rtl/wcrs_divider.sv */
// Pipelined restoring divider: quotient = (num << FRAC_BITS) / den, one
// quotient bit per stage. Numerator is known to be below den, so the
// quotient fits in FRAC_BITS bits.
module wcrs_divider #(
    parameter int STEP_BITS = 24,
    parameter int FRAC_BITS = 16,
    parameter int TAG_BITS  = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [STEP_BITS-1:0] num,
    input  logic [STEP_BITS-1:0] den,
    input  logic [TAG_BITS-1:0]  in_tag,
    output logic                 out_valid,
    output logic [FRAC_BITS-1:0] quot,
    output logic [TAG_BITS-1:0]  out_tag
);

    logic                 vld_reg  [FRAC_BITS+1];
    logic [STEP_BITS:0]   rem_reg  [FRAC_BITS+1];
    logic [STEP_BITS-1:0] den_reg  [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] q_reg    [FRAC_BITS+1];
    logic [TAG_BITS-1:0]  tag_reg  [FRAC_BITS+1];

    // Stage 0 valid capture and valid shift through all stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= FRAC_BITS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= FRAC_BITS; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Stage 0 data capture and shift-subtract stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= {1'b0, num};
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            tag_reg[0] <= in_tag;
            for (int i = 1; i <= FRAC_BITS; i++)
            begin
                logic [STEP_BITS+1:0] sh;
                logic [STEP_BITS+1:0] df;
                sh = {rem_reg[i-1], 1'b0};
                df = sh - {2'b00, den_reg[i-1]};
                if (!df[STEP_BITS+1])
                begin
                    rem_reg[i] <= df[STEP_BITS:0];
                    q_reg[i]   <= {q_reg[i-1][FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= sh[STEP_BITS:0];
                    q_reg[i]   <= {q_reg[i-1][FRAC_BITS-2:0], 1'b0};
                end
                den_reg[i] <= den_reg[i-1];
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[FRAC_BITS];
    assign quot      = q_reg[FRAC_BITS];
    assign out_tag   = tag_reg[FRAC_BITS];

endmodule

/* rtl/warmup_cosine_rate_schedule_top.sv */
// Warm-up / cosine-annealing schedule. Each step_number item yields one result item
// (sched_value, setup_error). Fully pipelined: one item per cycle while no held result
// stalls it. The warp table (sin^2 points) is computed at elaboration. Configuration
// must be written only when idle; the block itself does not enforce this.
module warmup_cosine_rate_schedule_top #(
    parameter int STEP_BITS     = 24,
    parameter int FRAC_BITS     = 16,
    parameter int WARP_SEGMENTS = 256,
    parameter int VALUE_BITS    = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [VALUE_BITS-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [STEP_BITS-1:0]         step_number,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VALUE_BITS-1:0] sched_value,
    output logic                         setup_error
);
    import wcrs_pkg::*;

    localparam int SEG_BITS = $clog2(WARP_SEGMENTS);
    localparam int VB = VALUE_BITS;
    localparam int FB = FRAC_BITS;
    localparam logic [FB:0] FONE = {1'b1, {FB{1'b0}}};

    typedef logic [FB:0] tab_t [WARP_SEGMENTS+1];

    function automatic tab_t build_tab();
        tab_t t;
        longint unsigned x, x2, tt, s, s2, e;
        for (int i = 0; i <= WARP_SEGMENTS; i++)
        begin
            x  = (64'd1686629713 * longint'(i)) / WARP_SEGMENTS;
            x2 = (x * x) >> 30;
            tt = 64'd1 << 30;
            // Horner terms, innermost first
            tt = (64'd1 << 30) - ((x2 * tt) >> 30) / 64'd156;
            tt = (64'd1 << 30) - ((x2 * tt) >> 30) / 64'd110;
            tt = (64'd1 << 30) - ((x2 * tt) >> 30) / 64'd72;
            tt = (64'd1 << 30) - ((x2 * tt) >> 30) / 64'd42;
            tt = (64'd1 << 30) - ((x2 * tt) >> 30) / 64'd20;
            tt = (64'd1 << 30) - ((x2 * tt) >> 30) / 64'd6;
            s = (x * tt) >> 30;
            if (s > (64'd1 << 30))
            begin
                s = 64'd1 << 30;
            end
            s2 = (s * s) >> 30;
            e = (s2 + (64'd1 << (29 - FB))) >> (30 - FB);
            if (e > (64'd1 << FB))
            begin
                e = 64'd1 << FB;
            end
            t[i] = e[FB:0];
        end
        t[0] = '0;
        t[WARP_SEGMENTS] = FONE;
        return t;
    endfunction

    localparam tab_t WTAB = build_tab();

    // Configuration registers
    logic [1:0]           mode_reg;
    logic [STEP_BITS-1:0] first_reg, last_reg, switch_reg;
    logic signed [VB-1:0] begin_reg, end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_LINEAR;
            first_reg  <= '0;
            last_reg   <= STEP_BITS'(1);
            switch_reg <= '0;
            begin_reg  <= '0;
            end_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[1:0];
                REG_FIRST:  first_reg  <= cfg_data[STEP_BITS-1:0];
                REG_LAST:   last_reg   <= cfg_data[STEP_BITS-1:0];
                REG_SWITCH: switch_reg <= cfg_data[STEP_BITS-1:0];
                REG_BEGIN:  begin_reg  <= cfg_data;
                REG_END:    end_reg    <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Global pipeline advance: stall everything while output is held
    logic adv;
    logic out_valid_reg;
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Static setup checks (config must stay stable while items are in flight; the block does not enforce it)
    logic err_c;
    always_comb
    begin
        case (mode_reg)
            MODE_LINEAR, MODE_COSINE: err_c = !(first_reg < last_reg);
            MODE_WARMUP: err_c = (begin_reg <= end_reg) || !(first_reg < switch_reg)
                                 || !(switch_reg < last_reg);
            default: err_c = 1'b1;
        endcase
    end

    // Stage A: span select and clamp; tag = {sat_hi, warp, warmup}
    logic                 a_v_reg;
    logic [STEP_BITS-1:0] a_num_reg, a_den_reg;
    logic [2:0]           a_tag_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= in_valid;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic [STEP_BITS-1:0] s0, s1;
            logic wu, wp;
            wu = (mode_reg == MODE_WARMUP) && (step_number < switch_reg);
            wp = (mode_reg == MODE_COSINE) || ((mode_reg == MODE_WARMUP) && !wu);
            s0 = (mode_reg == MODE_WARMUP && !wu) ? switch_reg : first_reg;
            s1 = wu ? switch_reg : last_reg;
            if (step_number <= s0)
            begin
                a_num_reg <= '0;
                a_den_reg <= STEP_BITS'(1);
                a_tag_reg <= {1'b0, wp, wu};
            end
            else if (step_number >= s1)
            begin
                a_num_reg <= '0;
                a_den_reg <= STEP_BITS'(1);
                a_tag_reg <= {1'b1, wp, wu};
            end
            else
            begin
                a_num_reg <= step_number - s0;
                a_den_reg <= s1 - s0;
                a_tag_reg <= {1'b0, wp, wu};
            end
        end
    end

    logic          d_v;
    logic [FB-1:0] d_q;
    logic [2:0]    d_tag;
    wcrs_divider #(.STEP_BITS(STEP_BITS), .FRAC_BITS(FB), .TAG_BITS(3)) u_div (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(a_v_reg),
        .num(a_num_reg), .den(a_den_reg), .in_tag(a_tag_reg),
        .out_valid(d_v), .quot(d_q), .out_tag(d_tag)
    );

    // Stage B: fraction, table lookup
    logic           b_v_reg, b_wp_reg, b_wu_reg;
    logic [FB:0]    b_f_reg, b_ta_reg, b_tb_reg;
    logic [FB-1:0]  b_rem_reg;
    logic           b_top_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_v_reg <= d_v;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic [FB:0] f;
            logic [FB+SEG_BITS:0] pos;
            logic [SEG_BITS:0] idx;
            f   = d_tag[2] ? FONE : {1'b0, d_q};
            pos = (FB+SEG_BITS+1)'(f) * (FB+SEG_BITS+1)'(WARP_SEGMENTS);
            idx = pos[FB+SEG_BITS:FB];
            b_f_reg   <= f;
            b_rem_reg <= pos[FB-1:0];
            b_top_reg <= (int'(idx) >= WARP_SEGMENTS);
            b_ta_reg  <= (int'(idx) >= WARP_SEGMENTS) ? FONE : WTAB[idx];
            b_tb_reg  <= (int'(idx) >= WARP_SEGMENTS) ? FONE : WTAB[idx + 1'b1];
            b_wp_reg  <= d_tag[1];
            b_wu_reg  <= d_tag[0];
        end
    end

    // Stage C: interpolation multiply; the linear span passes the fraction through
    logic        c_v_reg, c_wu_reg;
    logic [FB:0] c_w_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_v_reg <= b_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic [2*FB:0] prod;
            prod = (2*FB+1)'(b_tb_reg - b_ta_reg) * (2*FB+1)'(b_rem_reg);
            if (!b_wp_reg)
            begin
                c_w_reg <= b_f_reg;
            end
            else if (b_top_reg)
            begin
                c_w_reg <= FONE;
            end
            else
            begin
                c_w_reg <= b_ta_reg + prod[2*FB:FB];
            end
            c_wu_reg <= b_wu_reg;
        end
    end

    // Stage D: difference split into high and low parts
    logic                   e_v_reg, e_full_reg;
    logic signed [VB:0]     e_v0_reg, e_v1_reg, e_dh_reg;
    logic [FB-1:0]          e_dl_reg;
    logic [FB:0]            e_w_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_v_reg <= c_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic signed [VB:0] v0, v1, d;
            v0 = c_wu_reg ? '0 : (VB+1)'(begin_reg);
            v1 = c_wu_reg ? (VB+1)'(begin_reg) : (VB+1)'(end_reg);
            d  = v1 - v0;
            e_v0_reg   <= v0;
            e_v1_reg   <= v1;
            e_dh_reg   <= d >>> FB;
            e_dl_reg   <= d[FB-1:0];
            e_w_reg    <= c_w_reg;
            e_full_reg <= (c_w_reg >= FONE);
        end
    end

    // Stage E: products
    logic                     f_v_reg, f_full_reg;
    logic signed [VB+FB+1:0]  f_hi_reg;
    logic [2*FB:0]            f_lo_reg;
    logic signed [VB:0]       f_v0_reg, f_v1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_v_reg <= e_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // high part keeps only the bits left after the shift
            logic signed [VB+2:0] hp;
            hp = $signed(e_dh_reg[VB-FB:0]) * $signed({1'b0, e_w_reg});
            f_hi_reg   <= (VB+FB+2)'(hp);
            f_lo_reg   <= (2*FB+1)'(e_dl_reg) * (2*FB+1)'(e_w_reg);
            f_v0_reg   <= e_v0_reg;
            f_v1_reg   <= e_v1_reg;
            f_full_reg <= e_full_reg;
        end
    end

    // Stage F: final sum and output register
    logic signed [VB-1:0] val_reg;
    logic                 err_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= f_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic signed [VB+FB+1:0] sum;
            sum = (VB+FB+2)'(f_v0_reg) + f_hi_reg
                  + $signed((VB+FB+2)'(f_lo_reg[2*FB:FB]));
            if (err_c)
            begin
                val_reg <= '0;
            end
            else if (f_full_reg)
            begin
                val_reg <= f_v1_reg[VB-1:0];
            end
            else
            begin
                val_reg <= sum[VB-1:0];
            end
            err_reg <= err_c;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sched_value = val_reg;
    assign setup_error = err_reg;

endmodule

/* rtl/wcrs_checker.sv */
`include "assert_macros.svh"

// Port-level checks on the schedule block
module wcrs_checker #(
    parameter int STEP_BITS  = 24,
    parameter int VALUE_BITS = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic [STEP_BITS-1:0]  step_number,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [VALUE_BITS-1:0] sched_value,
    input logic                  setup_error
);

    // An error result carries a zero value
    `CHK_IMPL(a_err_zero, clk, rst_n, out_valid && setup_error, sched_value == '0, "error not zero")
    // Input is stalled only while a result is held
    `CHK_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "spurious stall")
    // Held result stays
    `CHK_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(sched_value), "result dropped")
    // Stalled input item stays
    `CHK_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(step_number), "input item changed")

endmodule

bind warmup_cosine_rate_schedule_top wcrs_checker #(
    .STEP_BITS(STEP_BITS), .VALUE_BITS(VALUE_BITS)
) u_wcrs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .step_number(step_number),
    .out_valid(out_valid), .out_stall(out_stall), .sched_value(sched_value),
    .setup_error(setup_error)
);
